FILE: design/mts_pkg.sv
// shared types and constants for the min tracking stack
// no dependencies
package mts_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CAP_W  = 8;
    localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic push;
        logic pop;
    } t_shift;

endpackage

FILE: design/mts_cell.sv
// one stack cell: holds an entry and shifts it toward or away from the top
// depends on mts_pkg
module mts_cell
    import mts_pkg::*;
(
    input  logic              i_clk,
    input  t_shift            i_shift,
    input  logic [DATA_W-1:0] i_above,
    input  logic [DATA_W-1:0] i_below,
    output logic [DATA_W-1:0] o_q
);

    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_shift.push) begin
            n_q = i_above;
        end else if (i_shift.pop) begin
            n_q = i_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

FILE: design/mts_chain.sv
// row of stack cells, top entry in cell 0
// depends on mts_pkg and mts_cell
module mts_chain
    import mts_pkg::*;
#(
    parameter int unsigned DEPTH = 128
) (
    input  logic              i_clk,
    input  t_shift            i_shift,
    input  logic [DATA_W-1:0] i_din,
    output logic [DATA_W-1:0] o_top,
    output logic [DATA_W-1:0] o_second
);

    logic [DATA_W-1:0] w_q [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_above;
        logic [DATA_W-1:0] w_below;

        if (g == 0) begin : g_first
            assign w_above = i_din;
        end else begin : g_mid
            assign w_above = w_q[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_below = w_q[g];
        end else begin : g_inner
            assign w_below = w_q[g+1];
        end

        mts_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_shift),
            .i_above (w_above),
            .i_below (w_below),
            .o_q     (w_q[g])
        );
    end

    assign o_top    = w_q[0];
    assign o_second = w_q[1];

endmodule

FILE: design/min_tracking_stack_top.sv
// min tracking stack: value stack and minimum stack as two shifting cell rows
// depends on mts_pkg and mts_chain
// the result word is registered when the input word is accepted and is valid in the next cycle
// throughput: one word per cycle; input stalls only while the result waits
// reset clears both counts and sets capacity to 128; stored entries are undefined
// until pushed
module min_tracking_stack_top
    import mts_pkg::*;
#(
    parameter int unsigned DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CAP_W-1:0]         i_cfg_capacity,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_kind,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_popped_value,
    output logic signed [DATA_W-1:0] o_min_value,
    output logic                     o_stack_empty,
    output logic [1:0]               o_status
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    logic [CAP_W-1:0]  r_capacity;
    logic [CNT_W-1:0]  r_val_count;
    logic [CNT_W-1:0]  r_min_count;
    logic [CNT_W-1:0]  n_val_count;
    logic [CNT_W-1:0]  n_min_count;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_popped;
    logic [DATA_W-1:0] r_min;
    logic              r_empty;
    t_status           r_status;

    logic [DATA_W-1:0] val_top;
    logic [DATA_W-1:0] val_second;
    logic [DATA_W-1:0] min_top;
    logic [DATA_W-1:0] min_second;
    t_shift            val_shift;
    t_shift            min_shift;

    logic              accept;
    logic              full;
    logic              push_ok;
    logic              pop_ok;
    logic [LIM_W-1:0]  cap_ext;
    logic [LIM_W-1:0]  limit;
    logic [DATA_W-1:0] n_min_top;
    logic [DATA_W-1:0] n_min_out;
    t_status           n_status;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;

    assign cap_ext = LIM_W'(r_capacity);
    assign limit   = (cap_ext < DEPTH_L) ? cap_ext : DEPTH_L;
    assign full    = LIM_W'(r_val_count) >= limit;

    assign push_ok = accept & (i_kind == KIND_PUSH) & ~full;
    assign pop_ok  = accept & (i_kind == KIND_POP) & (r_val_count != '0);

    always_comb begin
        val_shift.push = push_ok;
        val_shift.pop  = pop_ok;
        min_shift.push = push_ok & (r_min_count < DEPTH_C)
                       & ((r_min_count == '0)
                          || ($signed(min_top) >= $signed(i_push_value)));
        min_shift.pop  = pop_ok & (r_min_count != '0) & (min_top == val_top);
    end

    always_comb begin
        n_val_count = r_val_count;
        if (val_shift.push) begin
            n_val_count = r_val_count + CNT_W'(1);
        end else if (val_shift.pop) begin
            n_val_count = r_val_count - CNT_W'(1);
        end
        n_min_count = r_min_count;
        n_min_top   = min_top;
        if (min_shift.push) begin
            n_min_count = r_min_count + CNT_W'(1);
            n_min_top   = i_push_value;
        end else if (min_shift.pop) begin
            n_min_count = r_min_count - CNT_W'(1);
            n_min_top   = min_second;
        end
        n_min_out = ((n_val_count != '0) && (n_min_count != '0)) ? n_min_top : '0;
        n_status = ST_DONE;
        if (i_kind == KIND_PUSH && full) begin
            n_status = ST_OVERFLOW;
        end else if (i_kind == KIND_POP && r_val_count == '0) begin
            n_status = ST_UNDERFLOW;
        end
    end

    mts_chain #(.DEPTH(DEPTH)) u_val_chain (
        .i_clk    (i_clk),
        .i_shift  (val_shift),
        .i_din    (i_push_value),
        .o_top    (val_top),
        .o_second (val_second)
    );

    mts_chain #(.DEPTH(DEPTH)) u_min_chain (
        .i_clk    (i_clk),
        .i_shift  (min_shift),
        .i_din    (i_push_value),
        .o_top    (min_top),
        .o_second (min_second)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_val_count <= '0;
            r_min_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_capacity;
            end
            r_val_count <= n_val_count;
            r_min_count <= n_min_count;
            r_out_valid <= accept | (r_out_valid & i_out_stall);
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_popped <= pop_ok ? val_top : '0;
            r_min    <= n_min_out;
            r_empty  <= (n_val_count == '0);
            r_status <= n_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_popped;
    assign o_min_value    = r_min;
    assign o_stack_empty  = r_empty;
    assign o_status       = r_status;

    // second entry of the value row is only needed by the cells themselves
    logic unused_val_second;
    assign unused_val_second = ^val_second;

endmodule
